FILE: rtl/itp_pkg.sv
`default_nettype none
package itp_pkg;

  // Buffer and stack sizing.
  localparam int BUF_DEPTH   = 512;
  localparam int STACK_DEPTH = 512;
  localparam int BUF_AW      = $clog2(BUF_DEPTH);
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(BUF_DEPTH + 1);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  // Fixed field widths.
  localparam int ACT_W  = 2;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 10;
  localparam int STAT_W = 3;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CONVERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STAT_W-1:0] ST_ILLEGAL = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNBAL   = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd4;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_IMPL   = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_OR     = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_AND    = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_NOT    = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ     = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ     = 8'h7A;

  // One result beat.
  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic [LEN_W-1:0]  length;
    logic              last;
    logic [STAT_W-1:0] status;
  } res_t;

  // Operator precedence; the sentinel and anything else rank lowest.
  function automatic logic [2:0] prec(input logic [CHAR_W-1:0] c);
    logic [2:0] p;
    unique case (c)
      CH_RPAREN:     p = 3'd1;
      CH_IMPL:       p = 3'd2;
      CH_OR, CH_AND: p = 3'd3;
      CH_NOT:        p = 3'd4;
      default:       p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
           ((c >= CH_LA) && (c <= CH_LZ));
  endfunction

  function automatic logic is_op(input logic [CHAR_W-1:0] c);
    return (c == CH_IMPL) || (c == CH_OR) || (c == CH_AND) || (c == CH_NOT);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/itp_if.sv
`default_nettype none
// Command channel: action and character.
interface itp_in_if;
  logic                         valid;
  logic                         ready;
  logic [itp_pkg::ACT_W-1:0]    action;
  logic [itp_pkg::CHAR_W-1:0]   char_in;

  modport source (output valid, output action, output char_in, input ready);
  modport sink   (input valid, input action, input char_in, output ready);
endinterface

// Result channel: one beat per command.
interface itp_out_if;
  logic                         valid;
  logic                         ready;
  logic [itp_pkg::CHAR_W-1:0]   char_out;
  logic [itp_pkg::LEN_W-1:0]    length;
  logic                         last;
  logic [itp_pkg::STAT_W-1:0]   status;

  modport source (output valid, output char_out, output length, output last,
                  output status, input ready);
  modport sink   (input valid, input char_out, input length, input last,
                  input status, output ready);
endinterface
`default_nettype wire

FILE: rtl/itp_ram.sv
`default_nettype none
// Simple dual-port RAM: one write port, one read port with registered data.
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/infix_to_prefix_converter.sv
`default_nettype none
// Infix to prefix converter for logic expressions.
// Commands arrive on in_ch, one per beat: load one infix character, convert
// the loaded expression, or read the next prefix character. Every command
// yields exactly one result beat on out_ch (char_out, length, last, status).
// A load or an unused action code goes from S_IDLE to S_PUT, a read passes
// through S_RD first; out_ch.valid rises and in_ch is ready again at the
// same edge, as the result leaves S_PUT. A convert takes S_NEXT and S_CHAR
// per character, S_OPER per operator, S_PAREN and S_TOPLD per open
// parenthesis, another compare state and S_TOPLD per operator popped off
// the stack, and S_DRAIN at the end: each step waits on the registered read
// of the infix buffer or the operator stack RAM, and one sequencer handles
// one character at a time.
// Illegal characters, unbalanced parentheses and stack overflow end the
// conversion early with an error status and an empty prefix.
// Reset clears all counters and pointers; buffer contents are not cleared,
// as only written entries are ever read. in_ch is ready only while the
// sequencer is idle. A result waits in the output register while out_ch
// stalls; the next command may be accepted meanwhile, and its result is
// held until the output register frees up.
module infix_to_prefix_converter (
  input wire logic  clk,
  input wire logic  rst_n,
  itp_in_if.sink    in_ch,
  itp_out_if.source out_ch
);

  localparam int CNT_W  = itp_pkg::CNT_W;
  localparam int SP_W   = itp_pkg::SP_W;
  localparam int CHAR_W = itp_pkg::CHAR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_NEXT, S_CHAR, S_PAREN, S_OPER, S_DRAIN, S_TOPLD, S_PUT
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [CNT_W-1:0]  in_cnt_r, in_cnt_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  pc_r, pc_nxt;
  logic [CNT_W-1:0]  rp_r, rp_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [CHAR_W-1:0] top_r, top_nxt;
  logic [CHAR_W-1:0] cur_r, cur_nxt;
  itp_pkg::res_t     res_r, res_nxt;
  itp_pkg::res_t     out_data_r, out_data_nxt;
  logic              out_valid_r, out_valid_nxt;

  // RAM ports.
  logic                      ifx_we;
  logic [CHAR_W-1:0]         ifx_rdata;
  logic                      pfx_we;
  logic [CHAR_W-1:0]         pfx_wdata;
  logic [CHAR_W-1:0]         pfx_rdata;
  logic                      stk_we;
  logic [itp_pkg::STK_AW-1:0] stk_waddr;
  logic [CHAR_W-1:0]         stk_wdata;
  logic [CHAR_W-1:0]         stk_rdata;

  // Address arithmetic.
  logic [CNT_W-1:0] idx_dec;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] rp_inc;
  logic [SP_W-1:0]  sp_below;

  // Per-cycle actions of the sequencer.
  logic              emit_en;
  logic [CHAR_W-1:0] emit_data;
  logic              pop_en;
  logic              push_en;
  logic [CHAR_W-1:0] push_data;
  logic              conv_end;
  logic [2:0]        conv_status;
  logic              put_go;

  assign idx_dec  = idx_r - CNT_W'(1);
  assign rd_idx   = pc_r - CNT_W'(1) - rp_r;
  assign rp_inc   = rp_r + CNT_W'(1);
  assign sp_below = sp_r - SP_W'(2);
  assign put_go   = (state_r == S_PUT) && (!out_valid_r || out_ch.ready);

  itp_ram #(.WIDTH(CHAR_W), .DEPTH(itp_pkg::BUF_DEPTH)) u_infix (
    .clk   (clk),
    .we    (ifx_we),
    .waddr (in_cnt_r[itp_pkg::BUF_AW-1:0]),
    .wdata (in_ch.char_in),
    .raddr (idx_dec[itp_pkg::BUF_AW-1:0]),
    .rdata (ifx_rdata)
  );

  itp_ram #(.WIDTH(CHAR_W), .DEPTH(itp_pkg::BUF_DEPTH)) u_prefix (
    .clk   (clk),
    .we    (pfx_we),
    .waddr (pc_r[itp_pkg::BUF_AW-1:0]),
    .wdata (pfx_wdata),
    .raddr (rd_idx[itp_pkg::BUF_AW-1:0]),
    .rdata (pfx_rdata)
  );

  itp_ram #(.WIDTH(CHAR_W), .DEPTH(itp_pkg::STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (sp_below[itp_pkg::STK_AW-1:0]),
    .rdata (stk_rdata)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    in_cnt_nxt   = in_cnt_r;
    idx_nxt      = idx_r;
    pc_nxt       = pc_r;
    rp_nxt       = rp_r;
    sp_nxt       = sp_r;
    top_nxt      = top_r;
    cur_nxt      = cur_r;
    res_nxt      = res_r;
    ifx_we       = 1'b0;
    pfx_we       = 1'b0;
    pfx_wdata    = '0;
    stk_we       = 1'b0;
    stk_waddr    = sp_r[itp_pkg::STK_AW-1:0];
    stk_wdata    = '0;
    emit_en      = 1'b0;
    emit_data    = top_r;
    pop_en       = 1'b0;
    push_en      = 1'b0;
    push_data    = cur_r;
    conv_end     = 1'b0;
    conv_status  = itp_pkg::ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          res_nxt.char_out = '0;
          res_nxt.length   = itp_pkg::LEN_W'(pc_r);
          res_nxt.last     = 1'b0;
          res_nxt.status   = itp_pkg::ST_OK;
          state_nxt        = S_PUT;
          unique case (in_ch.action)
            itp_pkg::ACT_LOAD: begin
              if (in_cnt_r >= CNT_W'(itp_pkg::BUF_DEPTH)) begin
                res_nxt.status = itp_pkg::ST_FULL;
              end else begin
                ifx_we     = 1'b1;
                in_cnt_nxt = in_cnt_r + CNT_W'(1);
              end
            end
            itp_pkg::ACT_CONVERT: begin
              // Start with the sentinel alone on the stack.
              pc_nxt    = '0;
              rp_nxt    = '0;
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = itp_pkg::CH_HASH;
              top_nxt   = itp_pkg::CH_HASH;
              sp_nxt    = SP_W'(1);
              idx_nxt   = in_cnt_r;
              state_nxt = S_NEXT;
            end
            itp_pkg::ACT_READ: begin
              if (rp_r >= pc_r) begin
                res_nxt.status = itp_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        res_nxt.char_out = pfx_rdata;
        res_nxt.last     = (rp_inc == pc_r);
        rp_nxt           = rp_inc;
        state_nxt        = S_PUT;
      end
      S_NEXT: begin
        if (idx_r == '0) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt   = idx_dec;
          state_nxt = S_CHAR;
        end
      end
      S_CHAR: begin
        cur_nxt = ifx_rdata;
        priority if (ifx_rdata == itp_pkg::CH_SPACE) begin
          state_nxt = S_NEXT;
        end else if (ifx_rdata == itp_pkg::CH_RPAREN) begin
          if (sp_r >= SP_W'(itp_pkg::STACK_DEPTH)) begin
            conv_end    = 1'b1;
            conv_status = itp_pkg::ST_FULL;
          end else begin
            push_en   = 1'b1;
            push_data = ifx_rdata;
            state_nxt = S_NEXT;
          end
        end else if (itp_pkg::is_alnum(ifx_rdata)) begin
          emit_en   = 1'b1;
          emit_data = ifx_rdata;
          state_nxt = S_NEXT;
        end else if (ifx_rdata == itp_pkg::CH_LPAREN) begin
          state_nxt = S_PAREN;
        end else if (itp_pkg::is_op(ifx_rdata)) begin
          state_nxt = S_OPER;
        end else begin
          conv_end    = 1'b1;
          conv_status = itp_pkg::ST_ILLEGAL;
        end
      end
      S_PAREN: begin
        // Pop to the matching close parenthesis, then drop it.
        priority if (top_r == itp_pkg::CH_RPAREN) begin
          pop_en    = 1'b1;
          ret_nxt   = S_NEXT;
          state_nxt = S_TOPLD;
        end else if (top_r == itp_pkg::CH_HASH) begin
          conv_end    = 1'b1;
          conv_status = itp_pkg::ST_UNBAL;
        end else begin
          emit_en   = 1'b1;
          pop_en    = 1'b1;
          ret_nxt   = S_PAREN;
          state_nxt = S_TOPLD;
        end
      end
      S_OPER: begin
        priority if (itp_pkg::prec(top_r) >= itp_pkg::prec(cur_r)) begin
          emit_en   = 1'b1;
          pop_en    = 1'b1;
          ret_nxt   = S_OPER;
          state_nxt = S_TOPLD;
        end else if (sp_r >= SP_W'(itp_pkg::STACK_DEPTH)) begin
          conv_end    = 1'b1;
          conv_status = itp_pkg::ST_FULL;
        end else begin
          push_en   = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_DRAIN: begin
        priority if (top_r == itp_pkg::CH_HASH) begin
          conv_end = 1'b1;
        end else if (top_r == itp_pkg::CH_RPAREN) begin
          conv_end    = 1'b1;
          conv_status = itp_pkg::ST_UNBAL;
        end else begin
          emit_en   = 1'b1;
          pop_en    = 1'b1;
          ret_nxt   = S_DRAIN;
          state_nxt = S_TOPLD;
        end
      end
      S_TOPLD: begin
        // The entry under the popped one comes back from the stack RAM.
        top_nxt   = stk_rdata;
        state_nxt = ret_r;
      end
      S_PUT: begin
        if (put_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Append to the prefix buffer; characters past its end are dropped.
    if (emit_en && (pc_r < CNT_W'(itp_pkg::BUF_DEPTH))) begin
      pfx_we    = 1'b1;
      pfx_wdata = emit_data;
      pc_nxt    = pc_r + CNT_W'(1);
    end
    if (pop_en) begin
      sp_nxt = sp_r - SP_W'(1);
    end
    if (push_en) begin
      stk_we    = 1'b1;
      stk_wdata = push_data;
      top_nxt   = push_data;
      sp_nxt    = sp_r + SP_W'(1);
    end

    // Wrap up a conversion, successful or not.
    if (conv_end) begin
      in_cnt_nxt       = '0;
      rp_nxt           = '0;
      res_nxt.char_out = '0;
      res_nxt.last     = 1'b0;
      res_nxt.status   = conv_status;
      if (conv_status != itp_pkg::ST_OK) begin
        pc_nxt         = '0;
        res_nxt.length = '0;
      end else begin
        res_nxt.length = itp_pkg::LEN_W'(pc_r);
      end
      state_nxt = S_PUT;
    end
  end

  // Output register.
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (put_go) begin
      out_data_nxt  = res_r;
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      in_cnt_r    <= '0;
      idx_r       <= '0;
      pc_r        <= '0;
      rp_r        <= '0;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      in_cnt_r    <= in_cnt_nxt;
      idx_r       <= idx_nxt;
      pc_r        <= pc_nxt;
      rp_r        <= rp_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r      <= top_nxt;
    cur_r      <= cur_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.char_out = out_data_r.char_out;
  assign out_ch.length   = out_data_r.length;
  assign out_ch.last     = out_data_r.last;
  assign out_ch.status   = out_data_r.status;

  // The sentinel sits alone at the bottom whenever it is the cached top.
  a_sentinel_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_NEXT || state_r == S_CHAR || state_r == S_PAREN ||
      state_r == S_OPER || state_r == S_DRAIN) && (top_r == itp_pkg::CH_HASH))
    |-> (sp_r == SP_W'(1)))
    else $error("sentinel cached as top with other entries on the stack");

  // A top reload only follows a pop.
  a_topld_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TOPLD) |->
      ($past(state_r) == S_PAREN || $past(state_r) == S_OPER ||
       $past(state_r) == S_DRAIN))
    else $error("stack top reload without a pop");

  // Counters never pass the buffer size.
  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r <= CNT_W'(itp_pkg::BUF_DEPTH)) && (in_cnt_r <= CNT_W'(itp_pkg::BUF_DEPTH))
    && (rp_r <= pc_r))
    else $error("buffer counter out of range");

  // The last character of a read is always a good read.
  a_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last) |-> (out_data_r.status == itp_pkg::ST_OK))
    else $error("last flag on a failed result");

  // A result is loaded only from the put state.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == S_PUT))
    else $error("result beat raised outside the put state");

endmodule
`default_nettype wire

FILE: verif/infix_to_prefix_converter_tb.sv
`timescale 1ns / 1ps

module infix_to_prefix_converter_tb;

  localparam logic [itp_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 100_000;

  logic clk = 1'b0;
  logic rst_n;

  itp_in_if  in_ch ();
  itp_out_if out_ch ();

  infix_to_prefix_converter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the converter state.
  logic [itp_pkg::CHAR_W-1:0] infix_mem  [itp_pkg::BUF_DEPTH];
  logic [itp_pkg::CHAR_W-1:0] op_stack   [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::CHAR_W-1:0] prefix_mem [itp_pkg::BUF_DEPTH];
  int infix_len;
  int stack_depth;
  int prefix_len;
  int read_idx;

  // Traffic shaping knobs and bookkeeping.
  int   send_idle_pct;
  int   stall_pct;
  int   hold_request;
  itp_pkg::res_t result_q [$];
  logic [itp_pkg::CHAR_W-1:0] expr_q [$];
  int   beats_sent;
  int   beats_checked;
  int   conversions;
  int   rejected_conversions;
  int   fail_count;
  int   cycle_count;

  // Operator binding strength; the sentinel and all other bytes rank lowest.
  function automatic int char_rank(input logic [itp_pkg::CHAR_W-1:0] c);
    case (c)
      itp_pkg::CH_RPAREN:              return 1;
      itp_pkg::CH_IMPL:                return 2;
      itp_pkg::CH_OR, itp_pkg::CH_AND: return 3;
      itp_pkg::CH_NOT:                 return 4;
      default:                         return 0;
    endcase
  endfunction

  // Scan the loaded text right to left and build the reversed prefix form.
  function automatic logic [itp_pkg::STAT_W-1:0] run_conversion();
    logic [itp_pkg::CHAR_W-1:0] c;
    prefix_len = 0;
    op_stack[0] = itp_pkg::CH_HASH;
    stack_depth = 1;
    for (int i = infix_len - 1; i >= 0; i--) begin
      c = infix_mem[i];
      if (c == itp_pkg::CH_SPACE) begin
        // Spaces carry no meaning.
      end else if (c == itp_pkg::CH_RPAREN) begin
        if (stack_depth >= itp_pkg::STACK_DEPTH) return itp_pkg::ST_FULL;
        op_stack[stack_depth] = c;
        stack_depth++;
      end else if (itp_pkg::is_alnum(c)) begin
        prefix_mem[prefix_len] = c;
        prefix_len++;
      end else if (c == itp_pkg::CH_LPAREN) begin
        while (op_stack[stack_depth-1] != itp_pkg::CH_RPAREN) begin
          if (op_stack[stack_depth-1] == itp_pkg::CH_HASH) return itp_pkg::ST_UNBAL;
          prefix_mem[prefix_len] = op_stack[stack_depth-1];
          prefix_len++;
          stack_depth--;
        end
        stack_depth--;
      end else if (itp_pkg::is_op(c)) begin
        while (char_rank(op_stack[stack_depth-1]) >= char_rank(c)) begin
          prefix_mem[prefix_len] = op_stack[stack_depth-1];
          prefix_len++;
          stack_depth--;
        end
        if (stack_depth >= itp_pkg::STACK_DEPTH) return itp_pkg::ST_FULL;
        op_stack[stack_depth] = c;
        stack_depth++;
      end else begin
        return itp_pkg::ST_ILLEGAL;
      end
    end
    // Drain whatever is left above the sentinel.
    while (op_stack[stack_depth-1] != itp_pkg::CH_HASH) begin
      if (op_stack[stack_depth-1] == itp_pkg::CH_RPAREN) return itp_pkg::ST_UNBAL;
      prefix_mem[prefix_len] = op_stack[stack_depth-1];
      prefix_len++;
      stack_depth--;
    end
    return itp_pkg::ST_OK;
  endfunction

  // Apply one command to the shadow state and return the result it must give.
  function automatic itp_pkg::res_t predict_result(input logic [itp_pkg::ACT_W-1:0] act,
                                                   input logic [itp_pkg::CHAR_W-1:0] ch);
    itp_pkg::res_t r;
    r.char_out = '0;
    r.last     = 1'b0;
    r.status   = itp_pkg::ST_OK;
    case (act)
      itp_pkg::ACT_LOAD: begin
        if (infix_len >= itp_pkg::BUF_DEPTH) begin
          r.status = itp_pkg::ST_FULL;
        end else begin
          infix_mem[infix_len] = ch;
          infix_len++;
        end
      end
      itp_pkg::ACT_CONVERT: begin
        r.status = run_conversion();
        if (r.status != itp_pkg::ST_OK) prefix_len = 0;
        conversions++;
        if (r.status != itp_pkg::ST_OK) rejected_conversions++;
        infix_len = 0;
        read_idx  = 0;
      end
      itp_pkg::ACT_READ: begin
        if (read_idx >= prefix_len) begin
          r.status = itp_pkg::ST_EMPTY;
        end else begin
          r.char_out = prefix_mem[prefix_len - 1 - read_idx];
          read_idx++;
          r.last = (read_idx == prefix_len);
        end
      end
      default: begin
      end
    endcase
    r.length = prefix_len[itp_pkg::LEN_W-1:0];
    return r;
  endfunction

  function automatic logic [itp_pkg::CHAR_W-1:0] rand_operand();
    int pick;
    pick = $urandom_range(61);
    if (pick < 10) return itp_pkg::CH_0 + itp_pkg::CHAR_W'(pick);
    if (pick < 36) return itp_pkg::CH_UA + itp_pkg::CHAR_W'(pick - 10);
    return itp_pkg::CH_LA + itp_pkg::CHAR_W'(pick - 36);
  endfunction

  function automatic logic [itp_pkg::CHAR_W-1:0] rand_byte();
    return itp_pkg::CHAR_W'($urandom_range(255));
  endfunction

  // Random well-formed expression appended to expr_q.
  task automatic build_expr(input int depth);
    int pick;
    pick = (depth == 0) ? 0 : $urandom_range(4);
    case (pick)
      0, 1: expr_q.push_back(rand_operand());
      2: begin
        expr_q.push_back(itp_pkg::CH_NOT);
        build_expr(depth - 1);
      end
      3: begin
        build_expr(depth - 1);
        case ($urandom_range(2))
          0:       expr_q.push_back(itp_pkg::CH_IMPL);
          1:       expr_q.push_back(itp_pkg::CH_OR);
          default: expr_q.push_back(itp_pkg::CH_AND);
        endcase
        build_expr(depth - 1);
      end
      default: begin
        expr_q.push_back(itp_pkg::CH_LPAREN);
        build_expr(depth - 1);
        expr_q.push_back(itp_pkg::CH_RPAREN);
      end
    endcase
  endtask

  // Offer one command beat and record its expected result once accepted.
  task automatic send_cmd(input logic [itp_pkg::ACT_W-1:0] act,
                          input logic [itp_pkg::CHAR_W-1:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.action  <= act;
    in_ch.char_in <= ch;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    result_q.push_back(predict_result(act, ch));
    beats_sent++;
  endtask

  task automatic load_text(input string s);
    for (int k = 0; k < s.len(); k++) send_cmd(itp_pkg::ACT_LOAD, s[k]);
  endtask

  task automatic read_prefix(input int count);
    repeat (count) send_cmd(itp_pkg::ACT_READ, rand_byte());
  endtask

  // Stop sending and wait until every expected result beat has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_reset_state();
    read_prefix(1);
    send_cmd(ACT_UNUSED, 8'hFF);
    send_cmd(itp_pkg::ACT_CONVERT, 8'h00);
    read_prefix(1);
    wait_for_results();
  endtask

  task automatic test_operator_mix();
    load_text("(A + z)*~0>9");
    send_cmd(itp_pkg::ACT_CONVERT, 8'hA5);
    read_prefix(prefix_len + 1);
    load_text("a>~Z");
    send_cmd(itp_pkg::ACT_CONVERT, 8'h5A);
    read_prefix(prefix_len + 1);
    wait_for_results();
  endtask

  task automatic test_error_cases();
    // Illegal bytes, including the sentinel character itself.
    load_text("a#b");
    send_cmd(itp_pkg::ACT_CONVERT, 8'h00);
    read_prefix(1);
    send_cmd(itp_pkg::ACT_LOAD, itp_pkg::CH_LA);
    send_cmd(itp_pkg::ACT_LOAD, 8'h80);
    send_cmd(itp_pkg::ACT_CONVERT, 8'h00);
    // A close paren left on the stack, then an open paren with no partner.
    load_text(" a)");
    send_cmd(itp_pkg::ACT_CONVERT, 8'h00);
    load_text("(a");
    send_cmd(itp_pkg::ACT_CONVERT, 8'h00);
    read_prefix(1);
    send_cmd(ACT_UNUSED, 8'h00);
    wait_for_results();
  endtask

  task automatic test_full_buffers();
    // A wall of close parens fills the infix buffer, one more load finds it
    // full, and the conversion then overflows the operator stack.
    repeat (itp_pkg::BUF_DEPTH) send_cmd(itp_pkg::ACT_LOAD, itp_pkg::CH_RPAREN);
    send_cmd(itp_pkg::ACT_LOAD, itp_pkg::CH_NOT);
    send_cmd(itp_pkg::ACT_CONVERT, 8'h00);
    read_prefix(1);
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 300;
    expr_q.delete();
    build_expr(3);
    foreach (expr_q[k]) send_cmd(itp_pkg::ACT_LOAD, expr_q[k]);
    send_cmd(itp_pkg::ACT_CONVERT, 8'h00);
    read_prefix(prefix_len);
    wait_for_results();
  endtask

  // Mostly well-formed expressions, some broken ones, some raw noise.
  task automatic test_random_traffic(input int idle_pct, input int stall_in_pct,
                                     input int beat_count);
    int stop_at;
    int kind;
    int pos;
    int reads;
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    stop_at       = beats_sent + beat_count;
    while (beats_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        if (infix_len != 0) send_cmd(itp_pkg::ACT_CONVERT, rand_byte());
        expr_q.delete();
        build_expr($urandom_range(1, 4));
        if (kind >= 65) begin
          pos = $urandom_range(expr_q.size() - 1);
          case ($urandom_range(3))
            0:       expr_q[pos] = rand_byte();
            1:       expr_q.push_back(itp_pkg::CH_RPAREN);
            2:       expr_q.push_front(itp_pkg::CH_LPAREN);
            default: expr_q.delete(pos);
          endcase
        end
        foreach (expr_q[k]) begin
          if ($urandom_range(9) == 0) send_cmd(itp_pkg::ACT_LOAD, itp_pkg::CH_SPACE);
          send_cmd(itp_pkg::ACT_LOAD, expr_q[k]);
        end
        send_cmd(itp_pkg::ACT_CONVERT, rand_byte());
        reads = ($urandom_range(9) == 0) ? $urandom_range(prefix_len)
                                         : prefix_len + $urandom_range(1);
        read_prefix(reads);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 6))
          send_cmd(itp_pkg::ACT_W'($urandom_range(3)), rand_byte());
      end else begin
        repeat ($urandom_range(1, 8)) send_cmd(itp_pkg::ACT_LOAD, rand_byte());
        send_cmd(itp_pkg::ACT_CONVERT, rand_byte());
        read_prefix(prefix_len);
      end
    end
    wait_for_results();
  endtask

  // Result sink: random stalls, plus a long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Compare every accepted result beat against the oldest expectation.
  initial begin
    itp_pkg::res_t got;
    itp_pkg::res_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.char_out = out_ch.char_out;
        got.length   = out_ch.length;
        got.last     = out_ch.last;
        got.status   = out_ch.status;
        beats_checked++;
        if (result_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat char=%h len=%0d last=%b status=%0d",
                   $time, got.char_out, got.length, got.last, got.status);
        end else begin
          want = result_q.pop_front();
          if (got.char_out !== want.char_out || got.length !== want.length ||
              got.last !== want.last || got.status !== want.status) begin
            fail_count++;
            $display("%0t: expected char=%h len=%0d last=%b status=%0d,",
                     $time, want.char_out, want.length, want.last, want.status,
                     " got char=%h len=%0d last=%b status=%0d",
                     got.char_out, got.length, got.last, got.status);
          end
        end
      end
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timed out after %0d cycles with %0d results outstanding.",
                 cycle_count, result_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.action  <= itp_pkg::ACT_LOAD;
    in_ch.char_in <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 0;
    infix_len     = 0;
    stack_depth   = 0;
    prefix_len    = 0;
    read_idx      = 0;
    beats_sent    = 0;
    beats_checked = 0;
    conversions   = 0;
    rejected_conversions = 0;
    fail_count    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_operator_mix();
    test_error_cases();
    test_full_buffers();
    test_output_backpressure();
    test_random_traffic(0, 0, 170);
    test_random_traffic(86, 0, 160);
    test_random_traffic(0, 86, 160);
    test_random_traffic(26, 26, 160);

    repeat (20) @(posedge clk);
    $display("Sent %0d command beats and checked %0d result beats over %0d cycles.",
             beats_sent, beats_checked, cycle_count);
    $display("Ran %0d conversions, %0d of them rejected, with full buffers and long stalls.",
             conversions, rejected_conversions);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d result beats did not match.", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/itp_pkg.sv
rtl/itp_if.sv
rtl/itp_ram.sv
rtl/infix_to_prefix_converter.sv
verif/infix_to_prefix_converter_tb.sv
